// ===== src/edc_pkg.sv =====
// shared widths, beat layout types and helpers for the disc collision unit
// no dependencies; imported by every module of the block but edc_div
package edc_pkg;

  localparam int PosW  = 20;          // Q12.8 position
  localparam int VelW  = 16;          // Q8.8 velocity
  localparam int RadW  = 4;
  localparam int MassW = 4;
  localparam int DiscW = 2 * PosW + 2 * VelW + RadW + MassW;
  localparam int InW   = 2 * DiscW;   // 160 bits, whole bytes
  localparam int OutW  = 4 * VelW;

  localparam int DxW   = 22;          // center difference
  localparam int DvW   = VelW + 1;    // velocity difference
  localparam int LimW  = 16;          // contact distance, at most 38400
  localparam int Lim2W = 2 * LimW;
  localparam int SqW   = 44;          // squared distance
  localparam int PvW   = 35;          // one term of v.d
  localparam int VdW   = 36;          // v.d
  localparam int MagW  = 20;          // |d| times a mass
  localparam int KW    = 34;          // 2|v.d| while in contact
  localparam int MsW   = MassW + 1;
  localparam int DenW  = 36;          // |d|^2 times mass sum
  localparam int NumW  = MagW + KW;   // 54
  localparam int QuoW  = 18;          // impulse magnitude bound
  localparam int TermW = QuoW + 1;
  localparam int SumW  = TermW + 1;
  localparam int DdW   = 31;          // |d|^2 once in contact

  localparam logic [10:0] CenterPx = 11'd1280;  // 5 pixels in Q12.8

  typedef struct packed {
    logic                    hit;
    logic                    neg_x;
    logic                    neg_y;
    logic                    kneg;
    logic [MagW-1:0]         mag_xb;
    logic [MagW-1:0]         mag_yb;
    logic [MagW-1:0]         mag_xa;
    logic [MagW-1:0]         mag_ya;
    logic [KW-1:0]           kmag;
    logic [DenW-1:0]         den;
    logic signed [VelW-1:0]  avx;
    logic signed [VelW-1:0]  avy;
    logic signed [VelW-1:0]  bvx;
    logic signed [VelW-1:0]  bvy;
  } front_t;

  typedef struct packed {
    logic                    hit;
    logic                    tneg_x;
    logic                    tneg_y;
    logic signed [VelW-1:0]  avx;
    logic signed [VelW-1:0]  avy;
    logic signed [VelW-1:0]  bvx;
    logic signed [VelW-1:0]  bvy;
  } side_t;

  function automatic logic signed [VelW-1:0] sat_vel(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32767);
    lo = -SumW'(32768);
    if (x > hi) begin
      sat_vel = 16'sh7fff;
    end else if (x < lo) begin
      sat_vel = 16'sh8000;
    end else begin
      sat_vel = x[VelW-1:0];
    end
  endfunction

endpackage

// ===== src/edc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// unsigned; numerator high part must be below the divisor; uses no package items
module edc_div #(
  parameter int NumW = 54,
  parameter int DenW = 36,
  parameter int QuoW = 18
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic [QuoW-1:0] quo
);

  logic [DenW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [DenW-1:0] rem_i;
    logic [DenW-1:0] den_i;
    logic [QuoW-1:0] low_i;
    logic [QuoW-1:0] quo_i;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (s == 0) begin : g_first
      assign rem_i = num[NumW-1:QuoW];
      assign low_i = num[QuoW-1:0];
      assign den_i = den;
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_q[s-1];
      assign low_i = low_q[s-1];
      assign den_i = den_q[s-1];
      assign quo_i = quo_q[s-1];
    end

    assign trial = {rem_i, low_i[QuoW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        low_q[s] <= {low_i[QuoW-2:0], 1'b0};
        den_q[s] <= den_i;
        quo_q[s] <= {quo_i[QuoW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QuoW-1];

endmodule

// ===== src/edc_front.sv =====
// geometry front end: centers, distances, contact test, impulse operands
// four register stages; depends on edc_pkg
module edc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [edc_pkg::InW-1:0] in_data,
  output logic                    out_valid,
  output edc_pkg::front_t         out_front
);
  import edc_pkg::*;

  // stage 1: differences
  logic signed [PosW-1:0]  apx, apy, bpx, bpy;
  logic signed [VelW-1:0]  avx, avy, bvx, bvy;
  logic [RadW-1:0]         ar, br;
  logic [MassW-1:0]        am, bm;
  logic signed [RadW:0]    rdif;
  logic signed [16:0]      roff;
  logic [RadW:0]           rsum;

  assign apx = in_data[19:0];
  assign apy = in_data[39:20];
  assign avx = in_data[55:40];
  assign avy = in_data[71:56];
  assign ar  = in_data[75:72];
  assign am  = in_data[79:76];
  assign bpx = in_data[99:80];
  assign bpy = in_data[119:100];
  assign bvx = in_data[135:120];
  assign bvy = in_data[151:136];
  assign br  = in_data[155:152];
  assign bm  = in_data[159:156];

  assign rdif = $signed({1'b0, br}) - $signed({1'b0, ar});
  assign roff = 17'(rdif) * $signed({6'b0, CenterPx});
  assign rsum = {1'b0, ar} + {1'b0, br};

  logic                    v1;
  logic signed [DxW-1:0]   dx1, dy1;
  logic signed [DvW-1:0]   vx1, vy1;
  logic [LimW-1:0]         lim1;
  logic [MassW-1:0]        am1, bm1;
  logic signed [VelW-1:0]  avx1, avy1, bvx1, bvy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1  <= DxW'(bpx) - DxW'(apx) + DxW'(roff);
      dy1  <= DxW'(bpy) - DxW'(apy) + DxW'(roff);
      vx1  <= DvW'(bvx) - DvW'(avx);
      vy1  <= DvW'(bvy) - DvW'(avy);
      lim1 <= LimW'(rsum) * LimW'(CenterPx);
      am1  <= am;
      bm1  <= bm;
      avx1 <= avx;
      avy1 <= avy;
      bvx1 <= bvx;
      bvy1 <= bvy;
    end
  end

  // stage 2: products
  logic [DxW-1:0] adx, ady;
  assign adx = dx1[DxW-1] ? DxW'(-dx1) : DxW'(dx1);
  assign ady = dy1[DxW-1] ? DxW'(-dy1) : DxW'(dy1);

  logic                    v2;
  logic signed [SqW-1:0]   sqx2, sqy2;
  logic signed [PvW-1:0]   pvx2, pvy2;
  logic [Lim2W-1:0]        lim2;
  logic [MagW-1:0]         mxb2, myb2, mxa2, mya2;
  logic                    nx2, ny2;
  logic [MsW-1:0]          ms2;
  logic signed [VelW-1:0]  avx2, avy2, bvx2, bvy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  // in contact |dx|,|dy| stay below 2^16, so the short operands are exact there
  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= SqW'(dx1) * SqW'(dx1);
      sqy2 <= SqW'(dy1) * SqW'(dy1);
      pvx2 <= PvW'(vx1) * PvW'($signed(dx1[17:0]));
      pvy2 <= PvW'(vy1) * PvW'($signed(dy1[17:0]));
      lim2 <= Lim2W'(lim1) * Lim2W'(lim1);
      mxb2 <= MagW'(adx[15:0]) * MagW'(bm1);
      myb2 <= MagW'(ady[15:0]) * MagW'(bm1);
      mxa2 <= MagW'(adx[15:0]) * MagW'(am1);
      mya2 <= MagW'(ady[15:0]) * MagW'(am1);
      nx2  <= dx1[DxW-1];
      ny2  <= dy1[DxW-1];
      ms2  <= {1'b0, am1} + {1'b0, bm1};
      avx2 <= avx1;
      avy2 <= avy1;
      bvx2 <= bvx1;
      bvy2 <= bvy1;
    end
  end

  // stage 3: sums
  logic                    v3;
  logic [SqW-1:0]          dd3;
  logic signed [VdW-1:0]   vd3;
  logic [Lim2W-1:0]        lim3;
  logic [MagW-1:0]         mxb3, myb3, mxa3, mya3;
  logic                    nx3, ny3;
  logic [MsW-1:0]          ms3;
  logic signed [VelW-1:0]  avx3, avy3, bvx3, bvy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd3  <= SqW'(sqx2) + SqW'(sqy2);
      vd3  <= VdW'(pvx2) + VdW'(pvy2);
      lim3 <= lim2;
      mxb3 <= mxb2;
      myb3 <= myb2;
      mxa3 <= mxa2;
      mya3 <= mya2;
      nx3  <= nx2;
      ny3  <= ny2;
      ms3  <= ms2;
      avx3 <= avx2;
      avy3 <= avy2;
      bvx3 <= bvx2;
      bvy3 <= bvy2;
    end
  end

  // stage 4: contact test and divider operands
  logic              hit_c;
  logic [VdW-1:0]    nvd;
  assign hit_c = (dd3 <= SqW'(lim3)) && (vd3 <= 0) && (dd3 != '0) && (ms3 != '0);
  assign nvd   = VdW'(-vd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_front.hit    <= hit_c;
      out_front.neg_x  <= nx3;
      out_front.neg_y  <= ny3;
      out_front.kneg   <= vd3[VdW-1];
      out_front.mag_xb <= mxb3;
      out_front.mag_yb <= myb3;
      out_front.mag_xa <= mxa3;
      out_front.mag_ya <= mya3;
      out_front.kmag   <= {nvd[KW-2:0], 1'b0};
      out_front.den    <= DenW'(dd3[DdW-1:0]) * DenW'(ms3);
      out_front.avx    <= avx3;
      out_front.avy    <= avy3;
      out_front.bvx    <= bvx3;
      out_front.bvy    <= bvy3;
    end
  end

endmodule

// ===== src/disc_elastic_collision_unit.sv =====
// top level of the two-disc elastic collision unit
// depends on edc_pkg, edc_front and edc_div
//
// one disc pair comes in as a beat on the s_ channel, one result beat leaves
// on the m_ channel for every pair, in order.
// input beat: both discs' position, velocity, radius and mass; output beat:
// the four new velocities in m_tdata and the collision flag in m_tuser.
// the pipeline has four geometry stages, one impulse multiply stage,
// 18 divider stages (one quotient bit each) and the output register.
// throughput is one pair per cycle unless the receiver stalls; the four velocity
// components each have their own pipelined divider, so nothing is shared between pairs.
// the whole pipeline advances together: when m_tready is low with a result
// waiting, every stage holds, bubbles included, and s_tready drops.
// reset clears all valid bits, so no beat is shown until a pair has passed
// through; there is no other state.
module disc_elastic_collision_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
  // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass
  input  logic [edc_pkg::InW-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // a_new_vel_x, a_new_vel_y, b_new_vel_x, b_new_vel_y
  output logic [edc_pkg::OutW-1:0] m_tdata,
  // collided
  output logic                     m_tuser
);
  import edc_pkg::*;

  logic en;
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  logic   fv;
  front_t fr;

  edc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (fv),
    .out_front (fr)
  );

  // impulse numerators: |d| * mass * 2|v.d|
  logic            v5;
  logic [NumW-1:0] num5 [4];
  logic [DenW-1:0] den5;
  side_t           side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num5[0]      <= NumW'(fr.mag_xb) * NumW'(fr.kmag);
      num5[1]      <= NumW'(fr.mag_yb) * NumW'(fr.kmag);
      num5[2]      <= NumW'(fr.mag_xa) * NumW'(fr.kmag);
      num5[3]      <= NumW'(fr.mag_ya) * NumW'(fr.kmag);
      den5         <= fr.den;
      side5.hit    <= fr.hit;
      side5.tneg_x <= fr.neg_x ^ fr.kneg;
      side5.tneg_y <= fr.neg_y ^ fr.kneg;
      side5.avx    <= fr.avx;
      side5.avy    <= fr.avy;
      side5.bvx    <= fr.bvx;
      side5.bvy    <= fr.bvy;
    end
  end

  logic [QuoW-1:0] quo [4];

  for (genvar g = 0; g < 4; g++) begin : g_div
    edc_div #(
      .NumW (NumW),
      .DenW (DenW),
      .QuoW (QuoW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num5[g]),
      .den (den5),
      .quo (quo[g])
    );
  end

  // side data and valid bits ride alongside the divider stages
  logic  vd [QuoW];
  side_t sd [QuoW];

  for (genvar s = 0; s < QuoW; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[s] <= 1'b0;
      end else if (en) begin
        vd[s] <= (s == 0) ? v5 : vd[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s] <= (s == 0) ? side5 : sd[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // signed impulse terms, update and saturation
  side_t                  so;
  logic signed [TermW-1:0] tx_a, ty_a, tx_b, ty_b;
  logic signed [VelW-1:0]  nax, nay, nbx, nby;

  assign so = sd[QuoW-1];

  always_comb begin
    tx_a = so.tneg_x ? -$signed({1'b0, quo[0]}) : $signed({1'b0, quo[0]});
    ty_a = so.tneg_y ? -$signed({1'b0, quo[1]}) : $signed({1'b0, quo[1]});
    tx_b = so.tneg_x ? -$signed({1'b0, quo[2]}) : $signed({1'b0, quo[2]});
    ty_b = so.tneg_y ? -$signed({1'b0, quo[3]}) : $signed({1'b0, quo[3]});
    nax  = sat_vel(SumW'(so.avx) + SumW'(tx_a));
    nay  = sat_vel(SumW'(so.avy) + SumW'(ty_a));
    nbx  = sat_vel(SumW'(so.bvx) - SumW'(tx_b));
    nby  = sat_vel(SumW'(so.bvy) - SumW'(ty_b));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd[QuoW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= so.hit;
      if (so.hit) begin
        m_tdata <= {nby, nbx, nay, nax};
      end else begin
        m_tdata <= {so.bvy, so.bvx, so.avy, so.avx};
      end
    end
  end

endmodule

// ===== sim/edc_checker.sv =====
// checker for the disc collision unit: watches both stream channels,
// predicts each result beat from the input beat and compares in order
// depends on edc_pkg for the beat widths
module edc_checker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [edc_pkg::InW-1:0]  s_tdata,
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [edc_pkg::OutW-1:0] m_tdata,
  input  logic                     m_tuser,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import edc_pkg::*;

  typedef struct packed {
    logic        collided;
    logic [15:0] bny;
    logic [15:0] bnx;
    logic [15:0] any;
    logic [15:0] anx;
  } velocities_t;

  velocities_t expected_velocities[$];

  function automatic longint clamp16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic velocities_t resolve_collision(input logic [InW-1:0] p);
    longint apx, apy, avx, avy, ar, am, bpx, bpy, bvx, bvy, br, bm;
    longint dx, dy, vx, vy, dd, lim, vd, msum, k, den;
    velocities_t r;
    apx = longint'($signed(p[19:0]));
    apy = longint'($signed(p[39:20]));
    avx = longint'($signed(p[55:40]));
    avy = longint'($signed(p[71:56]));
    ar = longint'(p[75:72]);
    am = longint'(p[79:76]);
    bpx = longint'($signed(p[99:80]));
    bpy = longint'($signed(p[119:100]));
    bvx = longint'($signed(p[135:120]));
    bvy = longint'($signed(p[151:136]));
    br = longint'(p[155:152]);
    bm = longint'(p[159:156]);
    dx = (bpx + 1280 * br) - (apx + 1280 * ar);
    dy = (bpy + 1280 * br) - (apy + 1280 * ar);
    vx = bvx - avx;
    vy = bvy - avy;
    dd = dx * dx + dy * dy;
    lim = 1280 * (ar + br);
    vd = vx * dx + vy * dy;
    msum = am + bm;
    r.collided = 1'b0;
    if (dd <= lim * lim && vd <= 0 && dd != 0 && msum != 0) begin
      k = 2 * vd;
      den = dd * msum;
      avx = clamp16(avx + (dx * k * bm) / den);
      avy = clamp16(avy + (dy * k * bm) / den);
      bvx = clamp16(bvx - (dx * k * am) / den);
      bvy = clamp16(bvy - (dy * k * am) / den);
      r.collided = 1'b1;
    end
    r.anx = avx[15:0];
    r.any = avy[15:0];
    r.bnx = bvx[15:0];
    r.bny = bvy[15:0];
    return r;
  endfunction

  assign pending = expected_velocities.size();

  always @(posedge clk) begin
    velocities_t want;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_velocities = {expected_velocities, resolve_collision(s_tdata)};
      end
      if (m_tvalid && m_tready) begin
        if (expected_velocities.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_velocities.pop_front();
          if (m_tdata[15:0] !== want.anx) begin
            $error("a_new_vel_x expected %h got %h", want.anx, m_tdata[15:0]);
            fail_count++;
          end
          if (m_tdata[31:16] !== want.any) begin
            $error("a_new_vel_y expected %h got %h", want.any, m_tdata[31:16]);
            fail_count++;
          end
          if (m_tdata[47:32] !== want.bnx) begin
            $error("b_new_vel_x expected %h got %h", want.bnx, m_tdata[47:32]);
            fail_count++;
          end
          if (m_tdata[63:48] !== want.bny) begin
            $error("b_new_vel_y expected %h got %h", want.bny, m_tdata[63:48]);
            fail_count++;
          end
          if (m_tuser !== want.collided) begin
            $error("collided expected %b got %b", want.collided, m_tuser);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_disc_elastic_collision_unit.sv =====
// stimulus top for the disc collision unit: clock, reset, disc pair beats,
// receiver stalls and the verdict; depends on edc_pkg, edc_checker and the block
module tb_disc_elastic_collision_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import edc_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
  logic [InW-1:0] s_tdata;
  logic [OutW-1:0] m_tdata;
  int fail_count, pending, send_idle, recv_stall, cycles;
  bit hold_off;

  disc_elastic_collision_unit dut (.*);
  edc_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("tb_disc_elastic_collision_unit NOT OK");
        $finish;
      end
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [DiscW-1:0] pack_disc(input logic [19:0] px, py,
      input logic [15:0] vx, vy, input logic [3:0] r, m);
    return {m, r, vy, vx, py, px};
  endfunction

  // two discs mostly near each other so that contacts are common
  function automatic logic [InW-1:0] random_pair();
    logic [19:0] apx, apy, bpx, bpy;
    logic [3:0] ar, br;
    int sel;
    sel = $urandom_range(9);
    apx = 20'($urandom);
    apy = 20'($urandom);
    ar = 4'($urandom_range(1, 15));
    br = 4'($urandom_range(1, 15));
    if (sel < 8) begin
      bpx = apx + 20'($signed($urandom_range(0, 40000)) - 20000);
      bpy = apy + 20'($signed($urandom_range(0, 40000)) - 20000);
    end else begin
      bpx = 20'($urandom);
      bpy = 20'($urandom);
    end
    if (sel == 0) begin
      bpx = apx + 20'(1280 * (ar - br));
      bpy = apy + 20'(1280 * (ar - br));
    end
    return {pack_disc(bpx, bpy, 16'($urandom), 16'($urandom), br,
                      4'($urandom_range(1, 15))),
            pack_disc(apx, apy, 16'($urandom), 16'($urandom), ar,
                      4'($urandom_range(1, 15)))};
  endfunction

  task automatic send_pair(input logic [InW-1:0] p);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= p;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    logic [InW-1:0] dir[$];
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    hold_off = 0;
    send_idle = 0;
    recv_stall = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // head-on contact, extremes, coincident centers, far apart, separating
    dir = {dir, {pack_disc(20'd2000, 20'd0, 16'h8000, 16'h0000, 4'd1, 4'd1),
                 pack_disc(20'd0, 20'd0, 16'h7fff, 16'h0000, 4'd1, 4'd1)}};
    dir = {dir, {pack_disc(20'd2000, 20'd0, 16'h7fff, 16'h0000, 4'd1, 4'd1),
                 pack_disc(20'd0, 20'd0, 16'h8000, 16'h0000, 4'd1, 4'd1)}};
    dir = {dir, {pack_disc(20'd0, 20'd0, 16'h1234, 16'h4321, 4'd15, 4'd15),
                 pack_disc(20'd0, 20'd0, 16'h0100, 16'h0200, 4'd15, 4'd1)}};
    dir = {dir, {pack_disc(20'h7ffff, 20'h7ffff, 16'h7fff, 16'h7fff, 4'd15, 4'd15),
                 pack_disc(20'h80000, 20'h80000, 16'h8000, 16'h8000, 4'd1, 4'd1)}};
    dir = {dir, {pack_disc(20'h80000, 20'h80000, 16'h8000, 16'h8000, 4'd15, 4'd15),
                 pack_disc(20'h7ffff, 20'h7ffff, 16'h7fff, 16'h7fff, 4'd15, 4'd15)}};
    dir = {dir, {pack_disc(20'd100, 20'd100, 16'h8000, 16'h8000, 4'd15, 4'd1),
                 pack_disc(20'd0, 20'd0, 16'h7fff, 16'h7fff, 4'd15, 4'd15)}};
    dir = {dir, {pack_disc(20'd1, 20'd0, 16'h0000, 16'h0000, 4'd1, 4'd15),
                 pack_disc(20'd0, 20'd0, 16'h0001, 16'h0000, 4'd1, 4'd15)}};
    dir = {dir, {pack_disc(20'd30000, 20'd1000, 16'h0000, 16'h0000, 4'd15, 4'd15),
                 pack_disc(20'd0, 20'd0, 16'h7fff, 16'h0000, 4'd15, 4'd15)}};
    foreach (dir[i]) send_pair(dir[i]);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 57; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 57; end
        3: begin send_idle = 28; recv_stall = 28; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 4) begin
        // fill the pipeline against a stopped receiver
        fork
          begin
            hold_off = 1;
            repeat (200) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      repeat (350) send_pair(random_pair());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("tb_disc_elastic_collision_unit OK");
    else $display("tb_disc_elastic_collision_unit NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/edc_pkg.sv
src/edc_div.sv
src/edc_front.sv
src/disc_elastic_collision_unit.sv
sim/edc_checker.sv
sim/tb_disc_elastic_collision_unit.sv
